@@ hw/rtl/ispf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, command codes and frame constants for the SPI ISP command framer.
// No dependencies.
package ispf_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned OpW    = 8;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FrameW = 72;
  localparam int unsigned PosW   = 7;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Command codes; code seven behaves as a tick
  localparam logic [CmdW-1:0] CMD_TICK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PEN   = 3'd1;
  localparam logic [CmdW-1:0] CMD_ERASE = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRB   = 3'd3;
  localparam logic [CmdW-1:0] CMD_WRW   = 3'd4;
  localparam logic [CmdW-1:0] CMD_RDB   = 3'd5;
  localparam logic [CmdW-1:0] CMD_RDW   = 3'd6;

  localparam logic [31:0] PenWord   = 32'hAA55AC53;
  localparam logic [23:0] EraseWord = 24'hAA558A;
  localparam logic [15:0] Preamble  = 16'hAA55;

  localparam logic [PosW-1:0] LenPen   = 7'd32;
  localparam logic [PosW-1:0] LenErase = 7'd24;
  localparam logic [PosW-1:0] LenShort = 7'd48;
  localparam logic [PosW-1:0] LenLong  = 7'd72;
  localparam logic [PosW-1:0] DataPhaseStart = 7'd40;

  // One classified beat handed from the front to the back
  typedef struct packed {
    logic              start;
    logic              is_read;
    logic [PosW-1:0]   len;
    logic [FrameW-1:0] frame;
    logic              miso;
  } ispf_entry_t;

  typedef struct packed {
    logic             select_n;
    logic             mosi;
    logic             bit_valid;
    logic             frame_done;
    logic [DataW-1:0] read_data;
    logic             busy_res;
    logic             command_rejected;
  } ispf_res_t;

endpackage

@@ hw/rtl/ispf_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command/tick beats and result beats.
// Depends on ispf_pkg.
interface ispf_in_if import ispf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [OpW-1:0]   opcode;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;
  logic             miso;

  modport source(output valid, command, opcode, address, write_data, miso, input ready);
  modport sink(input valid, command, opcode, address, write_data, miso, output ready);
endinterface

interface ispf_out_if import ispf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             select_n;
  logic             mosi;
  logic             bit_valid;
  logic             frame_done;
  logic [DataW-1:0] read_data;
  logic             busy_res;
  logic             command_rejected;

  modport source(output valid, select_n, mosi, bit_valid, frame_done, read_data, busy_res,
                 command_rejected, input ready);
  modport sink(input valid, select_n, mosi, bit_valid, frame_done, read_data, busy_res,
               command_rejected, output ready);
endinterface

@@ hw/rtl/ispf_front.sv @@
`timescale 1ns / 1ps
// Front end: decodes each input beat into a start or tick entry, builds the
// outgoing frame word, and buffers entries in a short queue. Depends on ispf_pkg, ispf_if.
module ispf_front import ispf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ispf_in_if.sink     in_i,
  output ispf_entry_t q_entry_o,
  output logic        q_valid_o,
  input  logic        q_ready_i
);

  ispf_entry_t             dec;
  logic [39:0]             hdr;
  ispf_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]        cnt_q, cnt_d;
  logic                    push, pop;

  assign hdr = {Preamble, in_i.opcode, in_i.address};

  always_comb begin
    dec         = '0;
    dec.miso    = in_i.miso;
    unique case (in_i.command)
      CMD_PEN: begin
        dec.start = 1'b1;
        dec.len   = LenPen;
        dec.frame = {PenWord, {(FrameW - 32){1'b0}}};
      end
      CMD_ERASE: begin
        dec.start = 1'b1;
        dec.len   = LenErase;
        dec.frame = {EraseWord, {(FrameW - 24){1'b0}}};
      end
      CMD_WRB: begin
        dec.start = 1'b1;
        dec.len   = LenShort;
        dec.frame = {hdr, in_i.write_data[7:0], {(FrameW - 48){1'b0}}};
      end
      CMD_WRW: begin
        dec.start = 1'b1;
        dec.len   = LenLong;
        dec.frame = {hdr, in_i.write_data};
      end
      CMD_RDB, CMD_RDW: begin
        dec.start   = 1'b1;
        dec.is_read = 1'b1;
        dec.len     = (in_i.command == CMD_RDB) ? LenShort : LenLong;
        dec.frame   = {hdr, {(FrameW - 40){1'b0}}};
      end
      default: begin
        dec.start = 1'b0; // tick, and the unused code
      end
    endcase
  end

  assign in_i.ready = (cnt_q != QCntW'(QDepth));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

@@ hw/rtl/ispf_back.sv @@
`timescale 1ns / 1ps
// Back end: frame engine that shifts one SPI bit per tick entry, samples MISO
// in the read data phase, and registers the result beat. Depends on ispf_pkg, ispf_if.
module ispf_back import ispf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ispf_entry_t q_entry_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  ispf_out_if.source  out_o
);

  logic              active_q, active_d;
  logic              is_read_q, is_read_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_nxt;
  logic [PosW-1:0]   len_q, len_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [DataW-1:0]  rshift_q, rshift_d;
  logic              out_valid_q, out_valid_d;
  ispf_res_t         res_q, res_d;
  logic              pop;

  assign q_ready_o = !out_valid_q || out_o.ready;
  assign pop       = q_valid_i && q_ready_o;
  assign pos_nxt   = pos_q + 1'b1;

  always_comb begin
    active_d    = active_q;
    is_read_d   = is_read_q;
    pos_d       = pos_q;
    len_d       = len_q;
    frame_d     = frame_q;
    rshift_d    = rshift_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (pop) begin
      out_valid_d    = 1'b1;
      res_d          = '0;
      res_d.select_n = 1'b1;
      if (q_entry_i.start) begin
        res_d.select_n = 1'b0;
        res_d.busy_res = 1'b1;
        if (active_q) begin
          res_d.command_rejected = 1'b1;
        end else begin
          active_d  = 1'b1;
          is_read_d = q_entry_i.is_read;
          len_d     = q_entry_i.len;
          pos_d     = '0;
          frame_d   = q_entry_i.frame;
          rshift_d  = '0;
        end
      end else if (active_q) begin
        res_d.select_n  = 1'b0;
        res_d.bit_valid = 1'b1;
        res_d.mosi      = frame_q[FrameW-1];
        frame_d         = {frame_q[FrameW-2:0], 1'b0};
        if (is_read_q && (pos_q >= DataPhaseStart)) begin
          rshift_d = {rshift_q[DataW-2:0], q_entry_i.miso};
        end
        if (pos_nxt >= len_q) begin
          res_d.frame_done = 1'b1;
          res_d.read_data  = is_read_q ? rshift_d : '0;
          active_d         = 1'b0;
          pos_d            = '0;
        end else begin
          res_d.busy_res = 1'b1;
          pos_d          = pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      is_read_q   <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      is_read_q   <= is_read_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    rshift_q <= rshift_d;
    res_q    <= res_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.select_n         = res_q.select_n;
  assign out_o.mosi             = res_q.mosi;
  assign out_o.bit_valid        = res_q.bit_valid;
  assign out_o.frame_done       = res_q.frame_done;
  assign out_o.read_data        = res_q.read_data;
  assign out_o.busy_res         = res_q.busy_res;
  assign out_o.command_rejected = res_q.command_rejected;

endmodule

@@ hw/rtl/spi_isp_command_framer.sv @@
`timescale 1ns / 1ps
// SPI ISP command framer, top level. Instantiates ispf_front and ispf_back.
// Depends on ispf_pkg, ispf_if.
//
// Takes one beat per clock cycle while the two-entry queue has room, commands and
// ticks alike, and returns exactly one result beat for each. A command beat starts a
// frame (or is rejected while one runs); each tick beat moves one MSB-first bit. An
// input beat passes through the two-entry queue after the decoder and then the
// result register of the frame engine. Throughput is set by the frame engine, which
// takes one queued beat per cycle whenever the result register is free or being
// drained.
module spi_isp_command_framer import ispf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ispf_in_if.sink    in_i,
  ispf_out_if.source out_o
);

  ispf_entry_t q_entry;
  logic        q_valid;
  logic        q_ready;

  ispf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_entry_o (q_entry),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready)
  );

  ispf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_entry),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

endmodule

@@ hw/rtl/ispf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the SPI ISP command framer, bound to the top level.
// Depends on ispf_pkg.
module ispf_checker import ispf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             select_n_i,
  input logic             mosi_i,
  input logic             bit_valid_i,
  input logic             frame_done_i,
  input logic [DataW-1:0] read_data_i,
  input logic             busy_res_i,
  input logic             command_rejected_i
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(frame_done_i) && $stable(busy_res_i))
    else $error("result beat changed while stalled");

  // Last bit of a frame: a clock pulse with select still asserted and nothing left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> bit_valid_i && !select_n_i && !busy_res_i)
    else $error("frame end beat inconsistent");

  // MOSI and read data only ride on clock pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !bit_valid_i |-> !mosi_i && !frame_done_i && (read_data_i == '0))
    else $error("data shown without a clock pulse");

  // A rejected command leaves the running frame busy with select low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && command_rejected_i |-> busy_res_i && !select_n_i && !bit_valid_i)
    else $error("rejected command beat inconsistent");

endmodule

bind spi_isp_command_framer ispf_checker u_ispf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .select_n_i         (out_o.select_n),
  .mosi_i             (out_o.mosi),
  .bit_valid_i        (out_o.bit_valid),
  .frame_done_i       (out_o.frame_done),
  .read_data_i        (out_o.read_data),
  .busy_res_i         (out_o.busy_res),
  .command_rejected_i (out_o.command_rejected)
);

@@ tb/spi_isp_command_framer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for spi_isp_command_framer: command/tick beats in, one result beat out each.
// Depends on ispf_pkg, ispf_if and the framer RTL; predicts each result from a local frame model.
module spi_isp_command_framer_tb;
  import ispf_pkg::*;

  localparam logic [CmdW-1:0] CmdSeven   = 3'd7;  // unused code, acts as a tick
  localparam int              CycleLimit = 400000;
  localparam int              RandomBeats = 1200;
  localparam int              LongHold   = 300;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [OpW-1:0]   opcode;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic             miso;
  } isp_beat_t;

  logic clk_i;
  logic rst_ni;

  ispf_in_if  cmd_ch ();
  ispf_out_if res_ch ();

  spi_isp_command_framer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (res_ch)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Local copy of the frame engine state
  logic [CmdW-1:0]  run_kind   = CMD_TICK;
  logic [PosW-1:0]  run_pos    = '0;
  logic [OpW-1:0]   run_opcode = '0;
  logic [AddrW-1:0] run_addr   = '0;
  logic [DataW-1:0] run_wdata  = '0;
  logic [DataW-1:0] miso_shift = '0;
  logic             in_frame   = 1'b0;

  isp_beat_t pending_beats[$];
  ispf_res_t due_results[$];

  isp_beat_t next_beat;
  isp_beat_t seen_beat;
  ispf_res_t got_res;
  ispf_res_t want_res;

  int  errors = 0;
  int  beats_total = 0;
  int  beats_accepted = 0;
  int  results_seen = 0;
  int  reads_checked = 0;
  int  cycle_count = 0;
  int  framed_beats = 0;
  int  rejects_queued = 0;
  int  frames_by_kind[8];
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  send_gap = 0;
  int  send_pace = 0;
  int  sent_count = 0;
  int  sink_gap = 0;
  int  sink_pace = 0;
  int  sink_count = 0;
  int  long_hold = 0;
  int  long_holds_done = 0;
  int  drain_wait = 0;

  function automatic int frame_len(logic [CmdW-1:0] kind);
    case (kind)
      CMD_PEN:          return int'(LenPen);
      CMD_ERASE:        return int'(LenErase);
      CMD_WRB, CMD_RDB: return int'(LenShort);
      CMD_WRW, CMD_RDW: return int'(LenLong);
      default:          return 0;
    endcase
  endfunction

  function automatic bit is_read(logic [CmdW-1:0] kind);
    return kind == CMD_RDB || kind == CMD_RDW;
  endfunction

  // MOSI level at bit p of the running frame, MSB first
  function automatic logic frame_mosi(logic [CmdW-1:0] kind, int p);
    if (kind == CMD_PEN) return PenWord[31-p];
    if (kind == CMD_ERASE) return EraseWord[23-p];
    if (p < 16) return Preamble[15-p];
    if (p < 24) return run_opcode[23-p];
    if (p < DataPhaseStart) return run_addr[39-p];
    if (kind == CMD_WRB) return run_wdata[47-p];
    if (kind == CMD_WRW) return run_wdata[71-p];
    return 1'b0;  // read data phase holds MOSI low
  endfunction

  function automatic ispf_res_t frame_step(isp_beat_t b);
    ispf_res_t r;
    int        p;
    r = '0;
    r.select_n = 1'b1;
    if (b.command >= CMD_PEN && b.command <= CMD_RDW) begin
      r.select_n = 1'b0;
      r.busy_res = 1'b1;
      if (in_frame) begin
        r.command_rejected = 1'b1;
      end else begin
        run_kind   = b.command;
        run_pos    = '0;
        run_opcode = b.opcode;
        run_addr   = b.address;
        run_wdata  = b.write_data;
        miso_shift = '0;
        in_frame   = 1'b1;
      end
    end else if (in_frame) begin
      p = int'(run_pos);
      r.select_n  = 1'b0;
      r.bit_valid = 1'b1;
      r.mosi      = frame_mosi(run_kind, p);
      if (is_read(run_kind) && p >= DataPhaseStart) miso_shift = {miso_shift[DataW-2:0], b.miso};
      if (p + 1 >= frame_len(run_kind)) begin
        r.frame_done = 1'b1;
        if (is_read(run_kind)) r.read_data = miso_shift;
        in_frame = 1'b0;
        run_kind = CMD_TICK;
        run_pos  = '0;
      end else begin
        run_pos    = PosW'(p + 1);
        r.busy_res = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(int pace);
    if (pace == 0) return 0;
    if (pace == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic add_beat(logic [CmdW-1:0] cmd, logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                          logic [DataW-1:0] wdata, logic miso);
    isp_beat_t b;
    b.command    = cmd;
    b.opcode     = op;
    b.address    = addr;
    b.write_data = wdata;
    b.miso       = miso;
    pending_beats.push_back(b);
  endtask

  task automatic add_reject();
    add_beat(CmdW'($urandom_range(CMD_PEN, CMD_RDW)), OpW'($urandom), AddrW'($urandom),
             $urandom, 1'($urandom_range(0, 1)));
    rejects_queued++;
    framed_beats++;
  endtask

  // n bit-moving beats; noise mixes in rejected commands and code-seven ticks
  // miso_mode: 0 low, 1 high, 2 random
  task automatic add_ticks(int n, int noise, int miso_mode);
    logic            m;
    logic [CmdW-1:0] c;
    while (n > 0) begin
      if ($urandom_range(0, 99) < noise) begin
        add_reject();
      end else begin
        m = (miso_mode == 2) ? 1'($urandom_range(0, 1)) : miso_mode[0];
        c = (noise > 0 && $urandom_range(0, 5) == 0) ? CmdSeven : CMD_TICK;
        add_beat(c, OpW'($urandom), AddrW'($urandom), $urandom, m);
        framed_beats++;
        n--;
      end
    end
  endtask

  task automatic add_frame(logic [CmdW-1:0] cmd, logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                           logic [DataW-1:0] wdata, int noise, int miso_mode);
    add_beat(cmd, op, addr, wdata, 1'($urandom_range(0, 1)));
    frames_by_kind[cmd]++;
    framed_beats++;
    add_ticks(frame_len(cmd), noise, miso_mode);
  endtask

  task automatic note_mismatch(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  // Input acceptance, prediction, result checking and the watchdog
  always @(posedge clk_i) begin
    in_taken  <= cmd_ch.valid && cmd_ch.ready;
    out_taken <= res_ch.valid && res_ch.ready;
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen_beat.command    = cmd_ch.command;
        seen_beat.opcode     = cmd_ch.opcode;
        seen_beat.address    = cmd_ch.address;
        seen_beat.write_data = cmd_ch.write_data;
        seen_beat.miso       = cmd_ch.miso;
        due_results.push_back(frame_step(seen_beat));
        beats_accepted++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got_res.select_n         = res_ch.select_n;
        got_res.mosi             = res_ch.mosi;
        got_res.bit_valid        = res_ch.bit_valid;
        got_res.frame_done       = res_ch.frame_done;
        got_res.read_data        = res_ch.read_data;
        got_res.busy_res         = res_ch.busy_res;
        got_res.command_rejected = res_ch.command_rejected;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %p", $time, got_res);
        end else begin
          want_res = due_results.pop_front();
          note_mismatch("select_n", want_res.select_n, got_res.select_n);
          note_mismatch("mosi", want_res.mosi, got_res.mosi);
          note_mismatch("bit_valid", want_res.bit_valid, got_res.bit_valid);
          note_mismatch("frame_done", want_res.frame_done, got_res.frame_done);
          note_mismatch("read_data", want_res.read_data, got_res.read_data);
          note_mismatch("busy_res", want_res.busy_res, got_res.busy_res);
          note_mismatch("command_rejected", want_res.command_rejected,
                        got_res.command_rejected);
          if (want_res.frame_done && want_res.read_data != '0) reads_checked++;
        end
        results_seen++;
      end
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("%0t: timeout after %0d cycles, %0d of %0d beats accepted",
                 $time, cycle_count, beats_accepted, beats_total);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Beat driver: holds a beat until taken, then waits its drawn gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        next_beat = pending_beats.pop_front();
        cmd_ch.command    <= next_beat.command;
        cmd_ch.opcode     <= next_beat.opcode;
        cmd_ch.address    <= next_beat.address;
        cmd_ch.write_data <= next_beat.write_data;
        cmd_ch.miso       <= next_beat.miso;
        cmd_ch.valid      <= 1'b1;
        send_gap = draw_wait(send_pace);
        sent_count++;
        if (sent_count % 64 == 0) send_pace = $urandom_range(0, 2);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: per-beat stalls plus two long hold-offs to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        sink_gap = draw_wait(sink_pace);
        sink_count++;
        if (sink_count % 64 == 0) sink_pace = $urandom_range(0, 2);
      end
      if ((long_holds_done == 0 && results_seen >= 500) ||
          (long_holds_done == 1 && results_seen >= 1400)) begin
        long_hold = LongHold;
        long_holds_done++;
      end
      if (long_hold > 0) begin
        long_hold--;
        res_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int noise;
    rst_ni            = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_TICK;
    cmd_ch.opcode     = '0;
    cmd_ch.address    = '0;
    cmd_ch.write_data = '0;
    cmd_ch.miso       = 1'b0;
    res_ch.ready      = 1'b0;
    foreach (frames_by_kind[k]) frames_by_kind[k] = 0;

    // Directed: idle ticks, each frame kind, field extremes, rejects
    add_beat(CMD_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    add_beat(CmdSeven, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_frame(CMD_PEN, 8'h00, 16'h0000, 32'h0, 0, 0);
    add_beat(CMD_ERASE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    frames_by_kind[CMD_ERASE]++;
    add_reject();  // command right behind a command
    add_ticks(LenErase, 0, 1);
    add_frame(CMD_WRB, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1);
    add_frame(CMD_WRW, 8'h00, 16'h0000, 32'h0000_0000, 0, 1);
    add_frame(CMD_WRW, 8'h5A, 16'hA55A, 32'hA5A5_5A5A, 0, 0);
    add_frame(CMD_RDB, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 0, 1);
    add_frame(CMD_RDW, 8'h3C, 16'hFFFF, 32'h0, 30, 2);
    add_frame(CMD_RDW, 8'h00, 16'h8000, 32'h8000_0000, 0, 1);
    // reject on the last bit slot, then a new frame right after the done beat
    add_beat(CMD_RDB, 8'h80, 16'h0080, 32'h0000_0080, 1'b0);
    frames_by_kind[CMD_RDB]++;
    add_ticks(LenShort - 1, 0, 2);
    add_reject();
    add_ticks(1, 0, 1);
    add_frame(CMD_PEN, OpW'($urandom), AddrW'($urandom), $urandom, 10, 2);
    add_beat(CMD_TICK, 8'h00, 16'h0000, 32'h0, 1'b1);
    framed_beats = 0;

    // Random: mostly clean frames with random content, some noisy ones
    while (framed_beats < RandomBeats) begin
      noise = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(10, 40);
      add_frame(CmdW'($urandom_range(CMD_PEN, CMD_RDW)), OpW'($urandom), AddrW'($urandom),
                $urandom, noise, 2);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          add_beat(($urandom_range(0, 1) != 0) ? CmdSeven : CMD_TICK,
                   OpW'($urandom), AddrW'($urandom), $urandom, 1'($urandom_range(0, 1)));
        end
      end
    end
    beats_total = pending_beats.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_accepted < beats_total) @(posedge clk_i);
    while (due_results.size() != 0 && drain_wait < 5000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected result beats never arrived", $time, due_results.size());
    end

    $display("Ran %0d beats: frames pen %0d, erase %0d, wrb %0d, wrw %0d, rdb %0d, rdw %0d,",
             beats_total, frames_by_kind[CMD_PEN], frames_by_kind[CMD_ERASE],
             frames_by_kind[CMD_WRB], frames_by_kind[CMD_WRW], frames_by_kind[CMD_RDB],
             frames_by_kind[CMD_RDW]);
    $display("%0d busy rejects; checked %0d result beats (%0d nonzero reads), %0d long sink holds, %0d mismatches",
             rejects_queued, results_seen, reads_checked, long_holds_done, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
